### hdl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Default window depth (largest pattern supported)
  localparam int unsigned PATTERN_MAX_DEF = 32;

  // Fixed field widths
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned OFFSET_W  = 32;
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned CARE_W    = 32;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned PAT_REG_W = 64;
  localparam int unsigned PAT_BITS  = 4 * PAT_REG_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0    = 3'd0,
    REG_PAT1    = 3'd1,
    REG_PAT2    = 3'd2,
    REG_PAT3    = 3'd3,
    REG_CARE    = 3'd4,
    REG_LENGTH  = 3'd5,
    REG_BASE    = 3'd6
  } wbps_reg_e;

  // Pattern settings seen by the front end
  typedef struct packed {
    logic [PAT_BITS-1:0] pattern;
    logic [CARE_W-1:0]   care;
    logic [LEN_W-1:0]    length;
  } wbps_match_cfg_t;

  // One queued result: match flag and start offset (before base is added)
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] start;
  } wbps_entry_t;

endpackage

### hdl/wbps_front.sv
// ----------------------------------------------------------------------------
// wbps_front
// Accepts bytes, keeps the byte window and chunk run count, does the masked
// window compare and queues a result word on a match or at scan end.
// ----------------------------------------------------------------------------
module wbps_front import wbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [DATA_W-1:0]   data_byte_i,
  input  logic [OFFSET_W-1:0] byte_offset_i,
  input  logic                chunk_start_i,
  input  logic                scan_start_i,
  input  logic                scan_end_i,
  input  wbps_match_cfg_t     cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output wbps_entry_t         entry_o,
  output logic                done_o
);

  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [DATA_W-1:0] win_q [PATTERN_MAX];
  logic [DATA_W-1:0] win_d [PATTERN_MAX];
  logic [LW-1:0]     run_q, run_d, run_base;
  logic              done_q, done_d;
  logic [LW-1:0]     len_eff, len_m1;
  logic [IW-1:0]     widx;
  logic              all_ok, hit, accept, advance;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  // a finished scan ignores bytes until the next scan start
  assign advance    = accept && (scan_start_i || !done_q);

  always_comb begin
    // clamp the pattern length to the window depth
    if (cfg_i.length > LEN_W'(PATTERN_MAX)) begin
      len_eff = LW'(PATTERN_MAX);
    end else begin
      len_eff = LW'(cfg_i.length);
    end
    len_m1 = (len_eff == '0) ? '0 : len_eff - LW'(1);

    // shifted window, newest byte at index 0
    win_d[0] = data_byte_i;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_d[i] = win_q[i-1];
    end

    // run count since chunk start, saturating
    run_base = (scan_start_i || chunk_start_i) ? '0 : run_q;
    run_d    = (run_base < LW'(PATTERN_MAX)) ? run_base + LW'(1) : run_base;

    // masked compare: pattern byte k against window[len-1-k]
    all_ok = 1'b1;
    widx   = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if ((LW'(k) < len_eff) && cfg_i.care[k]) begin
        widx = IW'(len_m1 - LW'(k));
        if (win_d[widx] != cfg_i.pattern[8*k +: 8]) begin
          all_ok = 1'b0;
        end
      end
    end

    hit    = (len_eff == '0) || ((run_d >= len_eff) && all_ok);
    done_d = hit || scan_end_i;

    push_o        = advance && done_d;
    entry_o.found = hit;
    entry_o.start = ADDR_W'(byte_offset_i) - ADDR_W'(len_m1);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      done_q <= 1'b0;
    end else if (advance) begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // byte window (entries beyond the run count never produce a hit)
  always_ff @(posedge clk_i) begin
    if (advance) begin
      win_q <= win_d;
    end
  end

  assign done_o = done_q;

endmodule

### hdl/wbps_queue.sv
// ----------------------------------------------------------------------------
// wbps_queue
// Two-entry result queue between the compare front end and the output stage.
// ----------------------------------------------------------------------------
module wbps_queue import wbps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  wbps_entry_t entry_i,
  output logic        full_o,
  output logic        valid_o,
  output wbps_entry_t entry_o,
  input  logic        pop_i
);

  wbps_entry_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### hdl/wbps_back.sv
// ----------------------------------------------------------------------------
// wbps_back
// Output stage: adds the base address to the match start and holds the
// result word until the receiver takes it.
// ----------------------------------------------------------------------------
module wbps_back import wbps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  wbps_entry_t       q_entry_i,
  output logic              pop_o,
  input  logic [ADDR_W-1:0] base_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic [ADDR_W-1:0] match_address_o
);

  logic              out_valid_q, out_valid_d;
  logic              found_q;
  logic [ADDR_W-1:0] addr_q, addr_d;

  // load when the output register is empty or being drained
  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    addr_d = q_entry_i.found ? base_i + q_entry_i.start : '0;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      found_q <= q_entry_i.found;
      addr_q  <= addr_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;

endmodule

### hdl/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Masked byte signature scan over a stream of memory bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one memory byte per word with
//   its offset and chunk/scan markers. Output channel (out_valid_o/out_ready_i)
//   gives at most one word per scan: found_o=1 with base + match start, or
//   found_o=0 with address 0 when the scan ends without a match.
//   Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (pattern words
//   0-3, care mask, length, base). Write only while the block is idle.
// Timing:
//   One byte per cycle while the result queue is not full. The result is
//   written to the result queue at the edge that accepts the byte and then
//   loaded into the output register (where base is added) once that
//   register is empty or being drained, for the receiver to take.
//   The window shift and masked compare close in the accept cycle, so the
//   next byte sees the updated match state at once.
// Reset: window count and scan state clear; bytes are scanned right away.
// Stall: a held output word does not stop input; the two-entry queue absorbs
//   results, and in_ready_o drops only when it is full.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DATA_W-1:0]    data_byte_i,
  input  logic [OFFSET_W-1:0]  byte_offset_i,
  input  logic                 chunk_start_i,
  input  logic                 scan_start_i,
  input  logic                 scan_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [ADDR_W-1:0]    match_address_o
);

  wbps_match_cfg_t   cfg_q;
  logic [ADDR_W-1:0] base_q;
  logic              push, q_full, q_valid, pop, done;
  wbps_entry_t       push_entry, q_entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= '0;
      base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAT0:   cfg_q.pattern[0*PAT_REG_W +: PAT_REG_W] <= cfg_wdata_i;
        REG_PAT1:   cfg_q.pattern[1*PAT_REG_W +: PAT_REG_W] <= cfg_wdata_i;
        REG_PAT2:   cfg_q.pattern[2*PAT_REG_W +: PAT_REG_W] <= cfg_wdata_i;
        REG_PAT3:   cfg_q.pattern[3*PAT_REG_W +: PAT_REG_W] <= cfg_wdata_i;
        REG_CARE:   cfg_q.care   <= cfg_wdata_i[CARE_W-1:0];
        REG_LENGTH: cfg_q.length <= cfg_wdata_i[LEN_W-1:0];
        REG_BASE:   base_q       <= cfg_wdata_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  wbps_front #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .byte_offset_i (byte_offset_i),
    .chunk_start_i (chunk_start_i),
    .scan_start_i  (scan_start_i),
    .scan_end_i    (scan_end_i),
    .cfg_i         (cfg_q),
    .full_i        (q_full),
    .push_o        (push),
    .entry_o       (push_entry),
    .done_o        (done)
  );

  wbps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (pop)
  );

  wbps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .pop_o           (pop),
    .base_i          (base_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .match_address_o (match_address_o)
  );

`ifndef SYNTHESIS
  // a queued result always closes the scan
  a_push_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> done)
    else $error("result queued but scan not marked done");

  // no result from a finished scan until a new scan starts
  a_no_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && done && !scan_start_i) |-> !push)
    else $error("result produced after scan was done");

  // input back-pressure only comes from a held output word
  a_full_needs_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output register");
`endif

endmodule
